### hdl/mft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_pkg: shared constants of the max frequency tracker
// Default sizes, port field widths and stream packing shared by the top level
// and its checker.
// ----------------------------------------------------------------------------
package mft_pkg;

    localparam int NUM_KEYS_DEF  = 1024;
    localparam int MAX_COUNT_DEF = 255;

    // Fixed field widths on the ports.
    localparam int KEY_IN_W   = 10;
    localparam int MAXC_OUT_W = 8;

    // Stream packing, tdata widths rounded up to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    // Command codes carried in s_tuser.
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

endpackage

### hdl/mft_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/max_frequency_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_frequency_tracker: running maximum occurrence count of a key multiset
// Each input transfer adds or removes one occurrence of a key; each produces
// exactly one result transfer with the largest count held by any key.
// ----------------------------------------------------------------------------
// User notes: the s_ channel carries one command per transfer (s_tuser[0]:
// 0 = add, 1 = remove; s_tdata[9:0] = key). The m_ channel returns one
// result per command (m_tdata[7:0] = maximum count, low 8 bits; m_tuser[0] =
// error, set when an add hits MAX_COUNT, a remove hits a zero count or the
// key is not below NUM_KEYS; the command is then ignored). The state lives in
// two RAMs: a count per key and a table of how many keys hold each count,
// updated read-modify-write by a sequencer. A normal command runs from accept
// to the next accept through the key-count read, two reads of the
// count table and the result push; an error on the key count skips the
// count-table reads and an out-of-range key goes straight to the push. The
// sequencer serializes commands; the next is accepted only after the push. After
// reset a clearing pass over every address of both RAMs initializes them;
// s_tready stays low during it. A finished result waits in the output
// register while the next command is already accepted.
// ----------------------------------------------------------------------------
module max_frequency_tracker #(
    parameter int NUM_KEYS  = mft_pkg::NUM_KEYS_DEF,
    parameter int MAX_COUNT = mft_pkg::MAX_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mft_pkg::S_TDATA_W-1:0] s_tdata,  // [9:0] key, [15:10] zero
    input  logic [mft_pkg::S_TUSER_W-1:0] s_tuser,  // [0] command
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mft_pkg::M_TDATA_W-1:0] m_tdata,  // [7:0] max_count
    output logic [mft_pkg::M_TUSER_W-1:0] m_tuser   // [0] error
);

    localparam int KEY_W  = $clog2(NUM_KEYS);
    localparam int CNT_W  = $clog2(MAX_COUNT + 1);
    localparam int KPC_W  = $clog2(NUM_KEYS + 1);
    localparam int KPC_N  = MAX_COUNT + 1;
    localparam int CLR_N  = (NUM_KEYS > KPC_N) ? NUM_KEYS : KPC_N;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int OUT_W  = mft_pkg::MAXC_OUT_W;
    localparam int KIN_W  = mft_pkg::KEY_IN_W;

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_RD_KC    = 6'b000100,
        S_RD_KPC0  = 6'b001000,
        S_RD_KPC1  = 6'b010000,
        S_PUSH     = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic               cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;      // count before the update
    logic [CNT_W-1:0]   ncnt_reg, ncnt_next;    // count after the update
    logic [KPC_W-1:0]   kpcc_reg, kpcc_next;    // new number of keys at old count
    logic [CNT_W-1:0]   max_reg, max_next;
    logic               err_reg, err_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_max_reg, m_max_next;
    logic               m_err_reg, m_err_next;

    // RAM ports
    logic               kc_we;
    logic [KEY_W-1:0]   kc_waddr, kc_raddr;
    logic [CNT_W-1:0]   kc_wdata, kc_rdata;
    logic               kpc_we;
    logic [CNT_W-1:0]   kpc_waddr, kpc_raddr;
    logic [KPC_W-1:0]   kpc_wdata, kpc_rdata;

    // Input key widened or cut to the RAM address width.
    logic [KEY_W+KIN_W-1:0] key_ext;
    logic [KEY_W-1:0]       key_in;
    logic                   key_ok;
    logic                   cnt_bad;
    logic [CNT_W-1:0]       cnt_new;
    logic [CNT_W+OUT_W-1:0] max_ext;

    assign key_ext = {{KEY_W{1'b0}}, s_tdata[KIN_W-1:0]};
    assign key_in  = key_ext[KEY_W-1:0];
    assign key_ok  = (32'(s_tdata[KIN_W-1:0]) < NUM_KEYS);
    assign max_ext = {{OUT_W{1'b0}}, max_reg};

    // Count from the key-count RAM, checked against the command.
    assign cnt_bad = (cmd_reg == mft_pkg::CMD_REMOVE) ? (kc_rdata == '0)
                                                       : (32'(kc_rdata) >= MAX_COUNT);
    assign cnt_new = (cmd_reg == mft_pkg::CMD_REMOVE) ? (kc_rdata - CNT_W'(1))
                                                       : (kc_rdata + CNT_W'(1));

    mft_ram #(.WIDTH(CNT_W), .DEPTH(NUM_KEYS)) u_key_counts (
        .aclk  (aclk),
        .we    (kc_we),
        .waddr (kc_waddr),
        .wdata (kc_wdata),
        .raddr (kc_raddr),
        .rdata (kc_rdata)
    );

    mft_ram #(.WIDTH(KPC_W), .DEPTH(KPC_N)) u_keys_per_count (
        .aclk  (aclk),
        .we    (kpc_we),
        .waddr (kpc_waddr),
        .wdata (kpc_wdata),
        .raddr (kpc_raddr),
        .rdata (kpc_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        cnt_next      = cnt_reg;
        ncnt_next     = ncnt_reg;
        kpcc_next     = kpcc_reg;
        max_next      = max_reg;
        err_next      = err_reg;
        m_tvalid_next = m_tvalid_reg;
        m_max_next    = m_max_reg;
        m_err_next    = m_err_reg;

        kc_we     = 1'b0;
        kc_waddr  = key_reg;
        kc_wdata  = ncnt_reg;
        kc_raddr  = key_in;
        kpc_we    = 1'b0;
        kpc_waddr = cnt_reg;
        kpc_wdata = kpcc_reg;
        kpc_raddr = ncnt_reg;

        s_tready  = 1'b0;

        // Result register drains independently of the sequencer.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                // Zero every key count; count table gets NUM_KEYS at zero.
                kc_we     = (32'(clr_reg) < NUM_KEYS);
                kc_waddr  = clr_reg[KEY_W-1:0];
                kc_wdata  = '0;
                kpc_we    = (32'(clr_reg) < KPC_N);
                kpc_waddr = clr_reg[CNT_W-1:0];
                kpc_wdata = (clr_reg == '0) ? KPC_W'(NUM_KEYS) : '0;
                max_next  = '0;
                if (clr_reg == CLR_W'(CLR_N - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + CLR_W'(1);
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next = s_tuser[0];
                    key_next = key_in;
                    if (key_ok) begin
                        state_next = S_RD_KC;
                    end else begin
                        err_next   = 1'b1;
                        state_next = S_PUSH;
                    end
                end
            end
            S_RD_KC: begin
                if (cnt_bad) begin
                    err_next   = 1'b1;
                    state_next = S_PUSH;
                end else begin
                    kc_we      = 1'b1;
                    kc_wdata   = cnt_new;
                    cnt_next   = kc_rdata;
                    ncnt_next  = cnt_new;
                    kpc_raddr  = kc_rdata;
                    state_next = S_RD_KPC0;
                end
            end
            S_RD_KPC0: begin
                // Old count loses one key; fetch the entry at the new count.
                kpc_we     = 1'b1;
                kpc_waddr  = cnt_reg;
                kpc_wdata  = kpc_rdata - KPC_W'(1);
                kpcc_next  = kpc_rdata - KPC_W'(1);
                kpc_raddr  = ncnt_reg;
                state_next = S_RD_KPC1;
            end
            S_RD_KPC1: begin
                kpc_we    = 1'b1;
                kpc_waddr = ncnt_reg;
                kpc_wdata = kpc_rdata + KPC_W'(1);
                if (cmd_reg == mft_pkg::CMD_REMOVE) begin
                    // Max drops only when the last key at the max leaves it.
                    if ((cnt_reg == max_reg) && (kpcc_reg == '0)) begin
                        max_next = ncnt_reg;
                    end
                end else if (ncnt_reg > max_reg) begin
                    max_next = ncnt_reg;
                end
                err_next   = 1'b0;
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_max_next    = max_ext[OUT_W-1:0];
                    m_err_next    = err_reg;
                    err_next      = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            max_reg      <= '0;
            err_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            max_reg      <= max_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        cnt_reg   <= cnt_next;
        ncnt_reg  <= ncnt_next;
        kpcc_reg  <= kpcc_next;
        m_max_reg <= m_max_next;
        m_err_reg <= m_err_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_max_reg;
    assign m_tuser  = m_err_reg;

endmodule

### hdl/mft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mft_checker: port-level assertions for the max frequency tracker
// Watches the result stream and the reset behavior seen on the ports.
// ----------------------------------------------------------------------------
module mft_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mft_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mft_pkg::M_TUSER_W-1:0] m_tuser
);

    logic [mft_pkg::M_TDATA_W-1:0] prev_reg;
    logic [mft_pkg::M_TDATA_W-1:0] diff;
    logic                          m_xfer;

    assign m_xfer = m_tvalid && m_tready;
    assign diff   = m_tdata - prev_reg;

    // Last reported maximum (zero after reset).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (m_xfer) begin
            prev_reg <= m_tdata;
        end
    end

    // Stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // Maximum moves by at most one per result (modulo the 8-bit field).
    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer |-> ((diff == 8'd0) || (diff == 8'd1) || (diff == 8'hFF)))
        else $error("maximum moved by more than one");

    // Ignored command leaves the maximum unchanged.
    a_err_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_tuser[0]) |-> (m_tdata == prev_reg))
        else $error("error result changed the maximum");

    // Reset empties the output and starts the clearing pass.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !s_tready))
        else $error("block active right after reset");

endmodule

bind max_frequency_tracker mft_checker u_mft_checker (.*);

### tb/tb_max_frequency_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_frequency_tracker: self-checking bench for the max frequency tracker
// Streams add/remove commands into the block and keeps its own copy of the
// per-key counts, the count histogram and the running maximum. Every result
// transfer is compared with the oldest predicted result. Covers directed
// corner cases, count saturation, a long output hold-off and phased random
// traffic over small hot key sets, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_max_frequency_tracker;

    localparam int HOLD_CYCLES = 300;       // long sink hold-off
    localparam int DRAIN_CYCLES = 20;       // settle time after last result

    typedef struct packed {
        logic [mft_pkg::MAXC_OUT_W-1:0] max_count;
        logic                           err;
    } freq_result_t;

    typedef enum int {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_SLOW
    } sink_mode_t;

    // ------------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mft_pkg::S_TDATA_W-1:0] s_tdata  = '0;    // [9:0] key, [15:10] zero
    logic [mft_pkg::S_TUSER_W-1:0] s_tuser  = '0;    // [0] command
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mft_pkg::M_TDATA_W-1:0] m_tdata;          // [7:0] max_count
    logic [mft_pkg::M_TUSER_W-1:0] m_tuser;          // [0] error

    max_frequency_tracker DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow state of the multiset
    // ------------------------------------------------------------------------
    logic [mft_pkg::MAXC_OUT_W-1:0] key_count [mft_pkg::NUM_KEYS_DEF];
    int                             keys_at_count [mft_pkg::MAX_COUNT_DEF + 1];
    int                             tracked_max;

    freq_result_t pending_results[$];       // predicted, not yet seen
    int           fail_count = 0;

    // Source pacing
    bit           src_gaps_on = 1'b1;
    int           burst_left  = 0;

    // Sink control: the test raises hold_request, the sink process counts
    // out the hold-off and clears it.
    bit           hold_request = 1'b0;

    task automatic clear_shadow();
        for (int i = 0; i < mft_pkg::NUM_KEYS_DEF; i++) key_count[i] = '0;
        for (int i = 0; i <= mft_pkg::MAX_COUNT_DEF; i++) keys_at_count[i] = 0;
        keys_at_count[0] = mft_pkg::NUM_KEYS_DEF;
        tracked_max = 0;
    endtask

    // Applies one command to the shadow state and returns what the block
    // must report. Ignored commands leave everything as is.
    function automatic freq_result_t track_command(logic cmd,
                                                   logic [mft_pkg::KEY_IN_W-1:0] key);
        freq_result_t r;
        int           c;
        r.err = 1'b0;
        if (int'(key) >= mft_pkg::NUM_KEYS_DEF) begin
            r.err = 1'b1;
        end else begin
            c = int'(key_count[key]);
            if (cmd == mft_pkg::CMD_ADD) begin
                if (c >= mft_pkg::MAX_COUNT_DEF) begin
                    r.err = 1'b1;                   // count ceiling
                end else begin
                    keys_at_count[c]--;
                    keys_at_count[c + 1]++;
                    key_count[key] = mft_pkg::MAXC_OUT_W'(c + 1);
                    if (c + 1 > tracked_max) tracked_max = c + 1;
                end
            end else begin
                if (c == 0) begin
                    r.err = 1'b1;                   // nothing to remove
                end else begin
                    keys_at_count[c]--;
                    keys_at_count[c - 1]++;
                    key_count[key] = mft_pkg::MAXC_OUT_W'(c - 1);
                    // max only drops when the last holder of it leaves
                    if (c == tracked_max && keys_at_count[c] == 0)
                        tracked_max = c - 1;
                end
            end
        end
        r.max_count = mft_pkg::MAXC_OUT_W'(tracked_max);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Source: one command per call. Entered and left at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_command(logic cmd, logic [mft_pkg::KEY_IN_W-1:0] key);
        int gap;
        if (src_gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = {{(mft_pkg::S_TDATA_W - mft_pkg::KEY_IN_W){1'b0}}, key};
        s_tuser  = cmd;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(track_command(cmd, key));
        @(negedge aclk);
    endtask

    // Idle the source until every predicted result has come back.
    task automatic wait_all_results();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Sink: stretches of always-ready, coin-flip and mostly-stalled, plus the
    // long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin
        sink_mode_t mode;
        int         stretch_left;
        mode = SINK_ALWAYS;
        stretch_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            if (stretch_left == 0) begin
                mode = sink_mode_t'($urandom_range(0, 2));
                stretch_left = $urandom_range(10, 60);
            end
            stretch_left--;
            case (mode)
                SINK_ALWAYS: m_tready = 1'b1;
                SINK_COIN:   m_tready = 1'($urandom_range(0, 1));
                default:     m_tready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        freq_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: max_count=%0d error=%0d",
                       m_tdata[mft_pkg::MAXC_OUT_W-1:0], m_tuser[0]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[mft_pkg::MAXC_OUT_W-1:0] !== want.max_count) begin
                    $error("max_count mismatch: expected %0d, got %0d",
                           want.max_count, m_tdata[mft_pkg::MAXC_OUT_W-1:0]);
                    fail_count++;
                end
                if (m_tuser[0] !== want.err) begin
                    $error("error mismatch: expected %0d, got %0d", want.err, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner cases: end keys, alternating key bits, remove at zero, the max
    // holding while another key still holds it, and stepping down.
    task automatic test_directed();
        send_command(mft_pkg::CMD_ADD,    10'h000);
        send_command(mft_pkg::CMD_ADD,    10'h3FF);
        send_command(mft_pkg::CMD_ADD,    10'h3FF);   // max 2
        send_command(mft_pkg::CMD_REMOVE, 10'h3FF);   // sole holder leaves, max 1
        send_command(mft_pkg::CMD_REMOVE, 10'h3FF);   // key 0 still at 1, max stays
        send_command(mft_pkg::CMD_REMOVE, 10'h3FF);   // remove at zero
        send_command(mft_pkg::CMD_REMOVE, 10'h000);   // max 0
        send_command(mft_pkg::CMD_REMOVE, 10'h000);   // remove at zero
        send_command(mft_pkg::CMD_ADD,    10'h155);
        send_command(mft_pkg::CMD_ADD,    10'h2AA);
        send_command(mft_pkg::CMD_ADD,    10'h2AA);
        send_command(mft_pkg::CMD_ADD,    10'h155);   // two keys share max 2
        send_command(mft_pkg::CMD_REMOVE, 10'h2AA);   // max stays 2
        send_command(mft_pkg::CMD_REMOVE, 10'h155);   // max 1
        send_command(mft_pkg::CMD_REMOVE, 10'h155);
        send_command(mft_pkg::CMD_REMOVE, 10'h2AA);   // back to empty
        send_command(mft_pkg::CMD_ADD,    10'h200);
        send_command(mft_pkg::CMD_REMOVE, 10'h200);
        send_command(mft_pkg::CMD_REMOVE, 10'h001);   // never added
        wait_all_results();
    endtask

    // Climb one key to the ceiling, push past it, then empty it and push past
    // zero.
    task automatic test_saturation();
        for (int i = 0; i <= mft_pkg::MAX_COUNT_DEF + 1; i++)
            send_command(mft_pkg::CMD_ADD, 10'h3A5);
        for (int i = 0; i <= mft_pkg::MAX_COUNT_DEF + 1; i++)
            send_command(mft_pkg::CMD_REMOVE, 10'h3A5);
        wait_all_results();
    endtask

    // Hold the sink off long enough for the block to back up its input, keep
    // offering commands, then pause until everything has drained.
    task automatic test_backpressure();
        src_gaps_on  = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_command(1'($urandom_range(0, 3) == 0),
                         mft_pkg::KEY_IN_W'($urandom_range(0, 7)));
        end
        src_gaps_on = 1'b1;
        wait_all_results();
    endtask

    // Phases with different add/remove mixes over a small hot key set so the
    // counts and the max move in both directions; a fifth of the commands hit
    // arbitrary keys as noise.
    task automatic test_random_traffic();
        int                           add_pct [6] = '{75, 50, 25, 70, 30, 55};
        logic [mft_pkg::KEY_IN_W-1:0] hot [16];
        int                           pool;
        logic                         cmd;
        logic [mft_pkg::KEY_IN_W-1:0] key;
        for (int ph = 0; ph < 6; ph++) begin
            pool = $urandom_range(1, 16);
            for (int i = 0; i < 16; i++) hot[i] = mft_pkg::KEY_IN_W'($urandom);
            src_gaps_on = (ph != 3);                // one phase at full rate
            for (int n = 0; n < 220; n++) begin
                cmd = ($urandom_range(0, 99) < add_pct[ph]) ? mft_pkg::CMD_ADD
                                                            : mft_pkg::CMD_REMOVE;
                if ($urandom_range(0, 4) != 0) key = hot[$urandom_range(0, pool - 1)];
                else                           key = mft_pkg::KEY_IN_W'($urandom);
                send_command(cmd, key);
            end
        end
        src_gaps_on = 1'b1;
        wait_all_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence. The block runs a RAM clearing pass after reset and keeps
    // s_tready low meanwhile; the first send simply waits it out.
    // ------------------------------------------------------------------------
    initial begin
        clear_shadow();
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_saturation();
        test_backpressure();
        test_random_traffic();

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
